[src/mpf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel priority FIFO package
// Field widths, register indices and operation codes shared by the core and
// its checker.
// ----------------------------------------------------------------------------
package mpf_pkg;

    // Widths of the transaction fields and of the configuration port.
    localparam int OPCODE_W  = 2;
    localparam int PID_W     = 16;
    localparam int PRIO_W    = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    // Number of level priority registers on the configuration port.
    localparam int NUM_REGS  = 4;

    typedef logic signed [PRIO_W-1:0] t_prio;

    // Operation codes; the fourth code does nothing.
    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } t_opcode;

endpackage

[src/multilevel_priority_fifo_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel priority FIFO core
// One FIFO of process ids per priority level, sharing a single synchronous
// store, with push, pop and peek operations served by level index.
// ----------------------------------------------------------------------------
// Each transaction on the input channel produces exactly one result
// transaction, in the cycle after it is accepted. A new input transaction is
// taken every cycle while the result register is free or being drained, so
// the core sustains one operation per clock cycle. The store has a single
// port, which is written by a push and read by a peek in the
// cycle the operation is accepted. A push appends its id to the level whose
// configured priority equals the request (lowest index wins if several
// match) and fails when no level matches or that level is full. Pop and peek
// work on the highest-index non-empty level and fail when every level is
// empty. Priority registers may only be written while the core is idle.
// There is no clearing pass after reset: the store needs none, because an
// entry is only ever read after a push has written it.

module multilevel_priority_fifo_core #(
    parameter int LEVELS      = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port
    input  logic                               i_cfg_we,
    input  logic [mpf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mpf_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    // Input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [mpf_pkg::OPCODE_W-1:0]       i_opcode,
    input  logic [mpf_pkg::PID_W-1:0]          i_process_id,
    input  logic signed [mpf_pkg::PRIO_W-1:0]  i_priority_req,
    // Result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_ok,
    output logic [mpf_pkg::PID_W-1:0]          o_head_id,
    output logic                               o_all_empty
);

    localparam int LVL_W     = $clog2(LEVELS);
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // Per-level control state lives in flip-flops; the ids live in the store.
    mpf_pkg::t_prio     r_prio [LEVELS];
    logic [PTR_W-1:0]   r_head [LEVELS];
    logic [PTR_W-1:0]   r_tail [LEVELS];
    logic [OCC_W-1:0]   r_occ  [LEVELS];
    logic [PTR_W-1:0]   n_head [LEVELS];
    logic [PTR_W-1:0]   n_tail [LEVELS];
    logic [OCC_W-1:0]   n_occ  [LEVELS];

    // The shared id store, one block of QUEUE_DEPTH entries per level.
    logic [ID_BITS-1:0] r_store [MEM_DEPTH];
    logic [ID_BITS-1:0] r_rd_data;

    // Result register.
    logic               r_out_valid;
    logic               r_ok;
    logic               r_peek;
    logic               r_all_empty;

    logic               w_accept;
    mpf_pkg::t_opcode   w_op;
    logic               w_match_hit;
    logic [LVL_W-1:0]   w_match_lvl;
    logic               w_any_busy;
    logic [LVL_W-1:0]   w_top_lvl;
    logic               w_push_ok;
    logic               w_pop_ok;
    logic               w_peek_ok;
    logic               w_ok;
    logic               n_all_empty;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [ID_BITS-1:0] w_pid;

    // Advance a ring pointer, wrapping at the end of the level's block.
    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

    // A new transaction is taken unless a result is still held by a stalled
    // receiver.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_op       = mpf_pkg::t_opcode'(i_opcode);
    assign w_pid      = ID_BITS'(i_process_id);

    // Parallel equality match of the request against every level. Scanning
    // downwards lets the lowest matching index win when values repeat.
    always_comb begin
        w_match_hit = 1'b0;
        w_match_lvl = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_prio[i] == i_priority_req) begin
                w_match_hit = 1'b1;
                w_match_lvl = LVL_W'(i);
            end
        end
    end

    // Priority encoder: the highest-index level that holds an entry.
    always_comb begin
        w_any_busy = 1'b0;
        w_top_lvl  = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (r_occ[i] != '0) begin
                w_any_busy = 1'b1;
                w_top_lvl  = LVL_W'(i);
            end
        end
    end

    always_comb begin
        w_push_ok = 1'b0;
        w_pop_ok  = 1'b0;
        w_peek_ok = 1'b0;
        unique case (w_op)
            mpf_pkg::OP_PUSH: w_push_ok = w_match_hit &&
                                          (r_occ[w_match_lvl] != OCC_W'(QUEUE_DEPTH));
            mpf_pkg::OP_POP:  w_pop_ok  = w_any_busy;
            mpf_pkg::OP_PEEK: w_peek_ok = w_any_busy;
            default: ;
        endcase
    end

    assign w_ok = w_push_ok || w_pop_ok || w_peek_ok;

    assign w_wr_addr = ADDR_W'(w_match_lvl) * ADDR_W'(QUEUE_DEPTH)
                     + ADDR_W'(r_tail[w_match_lvl]);
    assign w_rd_addr = ADDR_W'(w_top_lvl) * ADDR_W'(QUEUE_DEPTH)
                     + ADDR_W'(r_head[w_top_lvl]);

    // Next pointer and occupancy values; only one level changes per
    // transaction.
    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            n_head[i] = r_head[i];
            n_tail[i] = r_tail[i];
            n_occ[i]  = r_occ[i];
        end
        if (w_accept && w_push_ok) begin
            n_tail[w_match_lvl] = wrap_next(r_tail[w_match_lvl]);
            n_occ[w_match_lvl]  = r_occ[w_match_lvl] + OCC_W'(1);
        end
        if (w_accept && w_pop_ok) begin
            n_head[w_top_lvl] = wrap_next(r_head[w_top_lvl]);
            n_occ[w_top_lvl]  = r_occ[w_top_lvl] - OCC_W'(1);
        end
    end

    // Emptiness of the whole queue once this transaction has taken effect.
    always_comb begin
        n_all_empty = 1'b1;
        for (int i = 0; i < LEVELS; i++) begin
            if (n_occ[i] != '0) begin
                n_all_empty = 1'b0;
            end
        end
    end

    // Control state, priority registers and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_prio[i] <= (i < mpf_pkg::NUM_REGS) ? mpf_pkg::PRIO_W'(i) : '0;
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_occ[i]  <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= n_head[i];
                r_tail[i] <= n_tail[i];
                r_occ[i]  <= n_occ[i];
                // Writes to indices beyond the level registers are dropped.
                if (i_cfg_we && (i < mpf_pkg::NUM_REGS) &&
                    (i_cfg_index == mpf_pkg::CFG_IDX_W'(i))) begin
                    r_prio[i] <= i_cfg_data;
                end
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; loaded only when a transaction is accepted, so it holds
    // while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok        <= w_ok;
            r_peek      <= w_peek_ok;
            r_all_empty <= n_all_empty;
        end
    end

    // Store: a push writes at the tail of its level, a peek reads the head of
    // the top level. Both cannot happen in one cycle, and a peek never reads
    // an entry in the cycle it is written.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_push_ok) begin
            r_store[w_wr_addr] <= w_pid;
        end
        if (w_accept && w_peek_ok) begin
            r_rd_data <= r_store[w_rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_ok;
    assign o_head_id   = r_peek ? mpf_pkg::PID_W'(r_rd_data) : '0;
    assign o_all_empty = r_all_empty;

endmodule

[src/mpf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel priority FIFO checker
// Port-level assertions on the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module mpf_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic                               o_ok,
    input logic [mpf_pkg::PID_W-1:0]          o_head_id,
    input logic                               o_all_empty
);

    // Every accepted transaction yields a result in the following cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted transaction produced no result");

    // A failed operation never reports a head id.
    a_fail_no_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_head_id == '0))
        else $error("failed operation reported a head id");

    // The input side is only held off while a result is stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a pending result");

    // A stalled result keeps its payload.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_ok) && $stable(o_head_id) && $stable(o_all_empty)))
        else $error("stalled result changed");

endmodule

bind multilevel_priority_fifo_core mpf_checker u_mpf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_ok           (o_ok),
    .o_head_id      (o_head_id),
    .o_all_empty    (o_all_empty)
);

[sim/multilevel_priority_fifo_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel priority FIFO core testbench
// Drives push, pop and peek transactions through the core under several
// level priority settings and compares every result transaction, field by
// field, with a cycle-free predictor of the level FIFOs.
// ----------------------------------------------------------------------------
// The predictor keeps its own copy of the level priority registers, the id
// store and the per-level pointers and fill counts. Each input transaction
// is predicted at the clock edge that accepts it, and the expected result is
// queued. A checker takes every accepted result transaction and compares it
// with the oldest queued expectation. Both channels idle at random: the
// sender waits a random gap before each transaction and the receiver stalls
// for a random time before each result, with stretches of no idling on
// either side. Handshakes are sampled on the falling edge, where every
// input has settled since the rising edge that drove it, and take effect
// on the following rising edge.

module multilevel_priority_fifo_core_tb;

    localparam int NUM_LEVELS  = 4;
    localparam int FIFO_DEPTH  = 16;
    localparam int CYCLE_LIMIT = 400000;

    // The fourth operation code is not used by the core and does nothing.
    localparam logic [mpf_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic                      ok;
        logic [mpf_pkg::PID_W-1:0] head_id;
        logic                      all_empty;
    } t_result;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_cfg_we       = 1'b0;
    logic [mpf_pkg::CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [mpf_pkg::CFG_DAT_W-1:0] i_cfg_data     = '0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_stall;
    logic [mpf_pkg::OPCODE_W-1:0]  i_opcode       = mpf_pkg::OP_PEEK;
    logic [mpf_pkg::PID_W-1:0]     i_process_id   = '0;
    mpf_pkg::t_prio                i_priority_req = '0;
    logic                          o_out_valid;
    logic                          i_out_stall    = 1'b0;
    logic                          o_ok;
    logic [mpf_pkg::PID_W-1:0]     o_head_id;
    logic                          o_all_empty;

    // Predictor state: level priorities, id store, read and write pointers
    // and the number of ids held in each level.
    mpf_pkg::t_prio            level_prio [NUM_LEVELS];
    logic [mpf_pkg::PID_W-1:0] id_store   [NUM_LEVELS][FIFO_DEPTH];
    int                        rd_ptr     [NUM_LEVELS];
    int                        wr_ptr     [NUM_LEVELS];
    int                        fill       [NUM_LEVELS];

    t_result pending_results[$];
    int      mismatches = 0;
    int      cycle_count = 0;
    bit      in_steady = 1'b0;
    bit      out_steady = 1'b0;

    multilevel_priority_fifo_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_process_id   (i_process_id),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_ok           (o_ok),
        .o_head_id      (o_head_id),
        .o_all_empty    (o_all_empty)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Guard against a hang: a correct run finishes far below this count.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("multilevel_priority_fifo_core verification failed");
            $finish;
        end
    end

    // Apply one operation to the predicted queue and return its result.
    // A push goes to the lowest-index level whose priority matches; pop and
    // peek always serve the highest-index level that holds anything.
    function automatic t_result apply_op(logic [mpf_pkg::OPCODE_W-1:0] op,
                                         logic [mpf_pkg::PID_W-1:0] pid,
                                         mpf_pkg::t_prio prio);
        t_result res;
        int      lvl;
        res = '0;
        lvl = -1;
        case (op) inside
            mpf_pkg::OP_PUSH: begin
                for (int i = 0; i < NUM_LEVELS; i++)
                    if (lvl < 0 && level_prio[i] == prio)
                        lvl = i;
                if (lvl >= 0 && fill[lvl] < FIFO_DEPTH) begin
                    id_store[lvl][wr_ptr[lvl]] = pid;
                    wr_ptr[lvl] = (wr_ptr[lvl] + 1) % FIFO_DEPTH;
                    fill[lvl]++;
                    res.ok = 1'b1;
                end
            end
            mpf_pkg::OP_POP, mpf_pkg::OP_PEEK: begin
                for (int i = NUM_LEVELS - 1; i >= 0; i--)
                    if (lvl < 0 && fill[i] != 0)
                        lvl = i;
                if (lvl >= 0) begin
                    res.ok = 1'b1;
                    if (op == mpf_pkg::OP_PEEK) begin
                        res.head_id = id_store[lvl][rd_ptr[lvl]];
                    end else begin
                        rd_ptr[lvl] = (rd_ptr[lvl] + 1) % FIFO_DEPTH;
                        fill[lvl]--;
                    end
                end
            end
            default: ;
        endcase
        res.all_empty = 1'b1;
        for (int i = 0; i < NUM_LEVELS; i++)
            if (fill[i] != 0)
                res.all_empty = 1'b0;
        return res;
    endfunction

    // Send one input transaction after a random gap and predict its result
    // at the edge that accepts it. The task is entered and left just after
    // a rising edge; valid stays high on exit so that back-to-back
    // transactions follow without an idle gap.
    task automatic send_op(input logic [mpf_pkg::OPCODE_W-1:0] op,
                           input logic [mpf_pkg::PID_W-1:0] pid,
                           input mpf_pkg::t_prio prio);
        int gap;
        bit accepted;
        gap = in_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_process_id   <= pid;
        i_priority_req <= prio;
        do begin
            @(negedge i_clk);
            accepted = !o_in_stall;
            @(posedge i_clk);
        end while (!accepted);
        pending_results.push_back(apply_op(op, pid, prio));
    endtask

    // Stop sending and wait until every expected result has been taken.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Write all four level priorities in turn, followed by a
    // write to an index past the last register, which the core ignores.
    task automatic set_levels(input int p0, input int p1, input int p2, input int p3);
        int vals [mpf_pkg::NUM_REGS + 1];
        vals = '{p0, p1, p2, p3, $urandom_range(0, 65535)};
        for (int i = 0; i <= mpf_pkg::NUM_REGS; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= mpf_pkg::CFG_IDX_W'((i < mpf_pkg::NUM_REGS) ?
                                               i : $urandom_range(mpf_pkg::NUM_REGS, 15));
            i_cfg_data  <= vals[i][mpf_pkg::CFG_DAT_W-1:0];
            @(posedge i_clk);
            if (i < mpf_pkg::NUM_REGS)
                level_prio[i] = mpf_pkg::t_prio'(vals[i]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Operations on an empty queue, the unused code, pushes that match no
    // level and one that matches level 3, all under the reset priorities.
    task automatic test_empty_queue;
        in_steady = 1'b0;
        send_op(mpf_pkg::OP_POP, 16'h0000, 16'sd0);
        send_op(mpf_pkg::OP_PEEK, 16'hFFFF, 16'sd3);
        send_op(OP_UNUSED, 16'hFFFF, -16'sd1);
        send_op(mpf_pkg::OP_PUSH, 16'hA5A5, 16'sd4);
        send_op(mpf_pkg::OP_PUSH, 16'h5A5A, 16'sh8000);
        send_op(mpf_pkg::OP_PUSH, 16'h1234, 16'sd3);
        send_op(OP_UNUSED, 16'h0000, 16'sd3);
        send_op(mpf_pkg::OP_POP, 16'h0000, 16'sd0);
        drain;
    endtask

    // Extreme priority values and extreme ids; level 3 must be served
    // before level 0.
    task automatic test_field_extremes;
        set_levels(-32768, -1, 0, 32767);
        send_op(mpf_pkg::OP_PUSH, 16'hFFFF, 16'sh8000);
        send_op(mpf_pkg::OP_PUSH, 16'h0000, 16'sd32767);
        send_op(mpf_pkg::OP_PEEK, 16'h0000, 16'sd0);
        send_op(mpf_pkg::OP_POP, 16'h0000, 16'sd0);
        send_op(mpf_pkg::OP_PEEK, 16'h0000, 16'sd0);
        send_op(mpf_pkg::OP_POP, 16'h0000, 16'sd0);
        send_op(mpf_pkg::OP_POP, 16'h0000, 16'sd0);
        drain;
    endtask

    // Descending priorities with a duplicate: service follows the level
    // index, and a push that matches two levels lands in the lower one.
    task automatic test_unsorted_levels;
        set_levels(100, 0, 0, -100);
        send_op(mpf_pkg::OP_PUSH, 16'h0100, 16'sd100);
        send_op(mpf_pkg::OP_PUSH, 16'h0001, 16'sd0);
        send_op(mpf_pkg::OP_PUSH, 16'h0300, -16'sd100);
        send_op(mpf_pkg::OP_PEEK, 16'h0000, 16'sd0);
        send_op(mpf_pkg::OP_POP, 16'h0000, 16'sd0);
        send_op(mpf_pkg::OP_PEEK, 16'h0000, 16'sd0);
        send_op(mpf_pkg::OP_POP, 16'h0000, 16'sd0);
        send_op(mpf_pkg::OP_PEEK, 16'h0000, 16'sd0);
        send_op(mpf_pkg::OP_POP, 16'h0000, 16'sd0);
        drain;
    endtask

    // Random bursts of mostly well-formed traffic: pushes aimed at a
    // configured level (long enough to fill it), runs of pops and peeks to
    // drain, mixed runs, near-miss priorities and pure noise.
    task automatic run_traffic(input int n_items);
        int                           sent;
        int                           kind;
        int                           len;
        int                           lvl;
        int                           pick;
        logic [mpf_pkg::OPCODE_W-1:0] op;
        mpf_pkg::t_prio               prio;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 20);
            lvl  = $urandom_range(0, NUM_LEVELS - 1);
            in_steady  = ($urandom_range(0, 3) == 0);
            out_steady = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < len; j++) begin
                pick = $urandom_range(0, 2);
                prio = mpf_pkg::t_prio'($urandom_range(0, 65535));
                op   = mpf_pkg::OP_PUSH;
                if (kind <= 3) begin
                    prio = level_prio[lvl];
                end else if (kind <= 6) begin
                    op = (pick == 0) ? mpf_pkg::OP_PEEK : mpf_pkg::OP_POP;
                end else if (kind == 7) begin
                    op = (pick == 0) ? mpf_pkg::OP_PUSH :
                         (pick == 1) ? mpf_pkg::OP_POP : mpf_pkg::OP_PEEK;
                    prio = level_prio[$urandom_range(0, NUM_LEVELS - 1)];
                end else if (kind == 8) begin
                    op = mpf_pkg::OPCODE_W'($urandom_range(0, 3));
                end else if (pick != 0) begin
                    prio = level_prio[lvl] + ((pick == 1) ? 16'sd1 : -16'sd1);
                end
                send_op(op, mpf_pkg::PID_W'($urandom_range(0, 65535)), prio);
                sent++;
            end
        end
        in_steady  = 1'b0;
        out_steady = 1'b0;
        drain;
    endtask

    // Random traffic under six priority settings: ordinary ascending values,
    // extremes, small repeats, all at the maximum, descending and random.
    task automatic test_random_traffic;
        int base;
        for (int phase = 0; phase < 6; phase++) begin
            base = $urandom_range(0, 65535 - 400) - 32768;
            case (phase)
                0: set_levels(base, base + $urandom_range(1, 100),
                              base + $urandom_range(101, 200),
                              base + $urandom_range(201, 300));
                1: set_levels(-32768, -1, 0, 32767);
                2: set_levels($urandom_range(0, 3) - 2, $urandom_range(0, 3) - 2,
                              $urandom_range(0, 3) - 2, $urandom_range(0, 3) - 2);
                3: set_levels(32767, 32767, 32767, 32767);
                4: set_levels(32767, 1000, -1000, -32768);
                default: set_levels($urandom_range(0, 65535), $urandom_range(0, 65535),
                                    $urandom_range(0, 65535), $urandom_range(0, 65535));
            endcase
            run_traffic(200);
        end
    endtask

    // Receiver: stall for a random number of cycles before each result,
    // then take it.
    initial begin : result_receiver
        int  hold;
        bit  taken;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            hold = out_steady ? 0 : $urandom_range(0, 7);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do begin
                @(negedge i_clk);
                taken = o_out_valid;
                @(posedge i_clk);
            end while (!taken);
        end
    end

    // Compare every result transaction with the oldest expectation.
    always @(negedge i_clk) begin : result_checker
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual ok %0d head_id %h all_empty %0d",
                         $time, o_ok, o_head_id, o_all_empty);
            end else begin
                want = pending_results.pop_front();
                if (o_ok !== want.ok) begin
                    mismatches++;
                    $display("%0t: ok expected %0d actual %0d", $time, want.ok, o_ok);
                end
                if (o_head_id !== want.head_id) begin
                    mismatches++;
                    $display("%0t: head_id expected %h actual %h",
                             $time, want.head_id, o_head_id);
                end
                if (o_all_empty !== want.all_empty) begin
                    mismatches++;
                    $display("%0t: all_empty expected %0d actual %0d",
                             $time, want.all_empty, o_all_empty);
                end
            end
        end
    end

    initial begin
        // Predictor state after reset: priorities 0 to 3, every level empty.
        for (int i = 0; i < NUM_LEVELS; i++) begin
            level_prio[i] = mpf_pkg::t_prio'(i);
            rd_ptr[i] = 0;
            wr_ptr[i] = 0;
            fill[i]   = 0;
            for (int k = 0; k < FIFO_DEPTH; k++)
                id_store[i][k] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue;
        test_field_extremes;
        test_unsorted_levels;
        test_random_traffic;

        drain;
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("multilevel_priority_fifo_core verification clean");
        end else begin
            $display("multilevel_priority_fifo_core verification failed");
        end
        $finish;
    end

endmodule
